@@ design/tsfc_pkg.sv @@
// Shared constants, codes and types for the touch sample filter/calibrate core.
// No dependencies; every other file in the design imports this package.
`default_nettype none

package tsfc_pkg;

    // Sample geometry
    localparam int ADC_BITS     = 12;
    localparam int SAMPLE_COUNT = 5;
    localparam int RAW_COUNT    = 5;
    localparam int RAW_W        = 12;
    localparam int MID          = SAMPLE_COUNT / 2;
    localparam int RANK_W       = $clog2(SAMPLE_COUNT);

    // Register field widths
    localparam int OFF_W     = 12;
    localparam int DIV_W     = 12;
    localparam int SPAN_W    = 10;
    localparam int FLIP_W    = 13;
    localparam int LIM_W     = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_DIVISOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SPAN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_DIVISOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SPAN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_FLIP       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT = 3'd7;

    // Register reset values
    localparam logic [OFF_W-1:0]  RST_X_OFFSET     = 12'd190;
    localparam logic [DIV_W-1:0]  RST_X_DIVISOR    = 12'd11;
    localparam logic [SPAN_W-1:0] RST_X_SPAN       = 10'd320;
    localparam logic [OFF_W-1:0]  RST_Y_OFFSET     = 12'd173;
    localparam logic [DIV_W-1:0]  RST_Y_DIVISOR    = 12'd8;
    localparam logic [SPAN_W-1:0] RST_Y_SPAN       = 10'd480;
    localparam logic [FLIP_W-1:0] RST_Y_FLIP       = 13'd4150;
    localparam logic [LIM_W-1:0]  RST_SPREAD_LIMIT = 12'd20;

    // Status codes
    localparam logic [1:0] ST_PEN_UP = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_SPREAD = 2'd2;
    localparam logic [1:0] ST_OK     = 2'd3;

    // Coordinate reported for anything but an accepted group
    localparam logic [SPAN_W-1:0] SCR_IDLE = 10'd1;

    // Divide-by-three through a reciprocal multiply
    localparam int SUM_W     = ADC_BITS + 2;
    localparam int RECIP_SH  = SUM_W + 1;
    localparam int RECIP_INT = ((2 ** RECIP_SH) + 2) / 3;
    localparam logic [SUM_W-1:0] RECIP = RECIP_INT[SUM_W-1:0];
    localparam int PROD_W    = 2 * SUM_W;

    // Signed numerator ahead of the divider, and its magnitude
    localparam int NUM_W = ((ADC_BITS > FLIP_W) ? ADC_BITS : FLIP_W) + 2;
    localparam int MAG_W = NUM_W - 1;
    localparam int CMP_W = (ADC_BITS > LIM_W) ? ADC_BITS : LIM_W;

    // Lane pipeline depth: rank, select, spread/sum, multiply, numerator,
    // one divider stage per quotient bit, map
    localparam int LANE_LAT = 5 + MAG_W + 1;

    typedef logic [ADC_BITS-1:0] t_samp;
    typedef t_samp t_samp_arr [SAMPLE_COUNT];
    typedef logic [RAW_W-1:0] t_raw;

    typedef struct packed {
        logic             pen_down;
        logic [RAW_W-1:0] raw_x0;
        logic [RAW_W-1:0] raw_x1;
        logic [RAW_W-1:0] raw_x2;
        logic [RAW_W-1:0] raw_x3;
        logic [RAW_W-1:0] raw_x4;
        logic [RAW_W-1:0] raw_y0;
        logic [RAW_W-1:0] raw_y1;
        logic [RAW_W-1:0] raw_y2;
        logic [RAW_W-1:0] raw_y3;
        logic [RAW_W-1:0] raw_y4;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [SPAN_W-1:0] screen_x;
        logic [SPAN_W-1:0] screen_y;
        logic              pressed;
    } t_out_item;

    // Per-lane flags that travel alongside the data
    typedef struct packed {
        logic zero;
        logic sok;
        logic neg;
    } t_side;

    // Per-lane calibration settings
    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [DIV_W-1:0]  divisor;
        logic [SPAN_W-1:0] span;
        logic [FLIP_W-1:0] flip;
        logic              flip_en;
        logic [LIM_W-1:0]  limit;
    } t_lane_cfg;

endpackage

`default_nettype wire

@@ design/tsfc_in_if.sv @@
// Input channel of the touch filter: valid/ready plus one group of raw samples.
// Depends on tsfc_pkg for the payload type.
`default_nettype none

interface tsfc_in_if;
    import tsfc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/tsfc_out_if.sv @@
// Output channel of the touch filter: valid/ready plus one calibrated result.
// Depends on tsfc_pkg for the payload type.
`default_nettype none

interface tsfc_out_if;
    import tsfc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/tsfc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side flags.
// Depends on tsfc_pkg for widths and the side-flag struct.
`default_nettype none

module tsfc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [tsfc_pkg::MAG_W-1:0] i_num,
    input  wire logic [tsfc_pkg::DIV_W-1:0] i_dvs,
    input  wire tsfc_pkg::t_side            i_side,
    output logic [tsfc_pkg::MAG_W-1:0]      o_quo,
    output tsfc_pkg::t_side                 o_side
);
    import tsfc_pkg::*;

    logic [DIV_W-1:0] r_rem  [MAG_W];
    logic [MAG_W-1:0] r_num  [MAG_W];
    logic [MAG_W-1:0] r_quo  [MAG_W];
    logic [DIV_W-1:0] r_dvs  [MAG_W];
    t_side            r_side [MAG_W];

    for (genvar k = 0; k < MAG_W; k++) begin : g_stage
        logic [DIV_W-1:0] w_rem_in;
        logic [MAG_W-1:0] w_num_in;
        logic [MAG_W-1:0] w_quo_in;
        logic [DIV_W-1:0] w_dvs_in;
        t_side            w_side_in;
        logic [DIV_W:0]   w_trial;
        logic [DIV_W:0]   w_diff;
        logic             w_ge;

        // Pick the previous stage, or the divider inputs for the first stage
        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_num_in  = i_num;
            assign w_quo_in  = '0;
            assign w_dvs_in  = i_dvs;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_num_in  = r_num[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_dvs_in  = r_dvs[k-1];
            assign w_side_in = r_side[k-1];
        end

        // Bring down the next dividend bit and trial-subtract
        assign w_trial = {w_rem_in, w_num_in[MAG_W-1]};
        assign w_ge    = (w_trial >= {1'b0, w_dvs_in});
        assign w_diff  = w_trial - {1'b0, w_dvs_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                r_num[k]  <= {w_num_in[MAG_W-2:0], 1'b0};
                r_quo[k]  <= {w_quo_in[MAG_W-2:0], w_ge};
                r_dvs[k]  <= w_dvs_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_quo  = r_quo[MAG_W-1];
    assign o_side = r_side[MAG_W-1];

endmodule

`default_nettype wire

@@ design/tsfc_lane.sv @@
// One axis lane: rank sort, middle-three spread check and mean, then the
// calibration map through the pipelined divider. Depends on tsfc_pkg, tsfc_div.
`default_nettype none

module tsfc_lane (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire tsfc_pkg::t_samp_arr         i_samp,
    input  wire tsfc_pkg::t_lane_cfg         i_cfg,
    output logic [tsfc_pkg::SPAN_W-1:0]      o_scr,
    output tsfc_pkg::t_side                  o_side
);
    import tsfc_pkg::*;

    // Stage 1: ranks and zero test
    t_samp             r_s1_samp [SAMPLE_COUNT];
    logic [RANK_W-1:0] r_s1_rank [SAMPLE_COUNT];
    logic              r_s1_zero;
    logic [RANK_W-1:0] n_s1_rank [SAMPLE_COUNT];
    logic              n_s1_zero;

    always_comb begin
        n_s1_zero = 1'b0;
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            n_s1_rank[i] = '0;
            if (i_samp[i] == '0) begin
                n_s1_zero = 1'b1;
            end
            for (int j = 0; j < SAMPLE_COUNT; j++) begin
                if ((j != i) && ((i_samp[j] < i_samp[i]) ||
                                 ((i_samp[j] == i_samp[i]) && (j < i)))) begin
                    n_s1_rank[i] = n_s1_rank[i] + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_samp <= i_samp;
            r_s1_rank <= n_s1_rank;
            r_s1_zero <= n_s1_zero;
        end
    end

    // Stage 2: pick the three middle samples by rank
    t_samp r_s2_mid [3];
    logic  r_s2_zero;
    t_samp n_s2_mid [3];

    always_comb begin
        for (int t = 0; t < 3; t++) begin
            n_s2_mid[t] = '0;
            for (int i = 0; i < SAMPLE_COUNT; i++) begin
                if (r_s1_rank[i] == RANK_W'(MID - 1 + t)) begin
                    n_s2_mid[t] = n_s2_mid[t] | r_s1_samp[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_mid  <= n_s2_mid;
            r_s2_zero <= r_s1_zero;
        end
    end

    // Stage 3: spread check and sum of the middle three
    logic [SUM_W-1:0] r_s3_sum;
    logic             r_s3_zero;
    logic             r_s3_sok;
    logic [CMP_W-1:0] w_gap_lo;
    logic [CMP_W-1:0] w_gap_hi;
    logic [CMP_W-1:0] w_lim;

    assign w_gap_lo = CMP_W'(r_s2_mid[1] - r_s2_mid[0]);
    assign w_gap_hi = CMP_W'(r_s2_mid[2] - r_s2_mid[1]);
    assign w_lim    = CMP_W'(i_cfg.limit);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_sum  <= SUM_W'(r_s2_mid[0]) + SUM_W'(r_s2_mid[1]) + SUM_W'(r_s2_mid[2]);
            r_s3_zero <= r_s2_zero;
            r_s3_sok  <= (w_gap_lo <= w_lim) && (w_gap_hi <= w_lim);
        end
    end

    // Stage 4: multiply by the reciprocal of three
    logic [PROD_W-1:0] r_s4_prod;
    logic              r_s4_zero;
    logic              r_s4_sok;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_prod <= PROD_W'(r_s3_sum) * PROD_W'(RECIP);
            r_s4_zero <= r_s3_zero;
            r_s4_sok  <= r_s3_sok;
        end
    end

    // Stage 5: form the signed numerator, split into sign and magnitude
    logic [PROD_W-1:0] w_avg_full;
    logic [NUM_W-1:0]  w_avg;
    logic [NUM_W-1:0]  w_num;
    logic [NUM_W-1:0]  w_num_neg;
    logic [MAG_W-1:0]  r_s5_mag;
    logic [DIV_W-1:0]  r_s5_dvs;
    t_side             r_s5_side;

    assign w_avg_full = r_s4_prod >> RECIP_SH;
    assign w_avg      = NUM_W'(w_avg_full[ADC_BITS-1:0]);
    assign w_num      = i_cfg.flip_en
                      ? (NUM_W'(i_cfg.flip) - w_avg - NUM_W'(i_cfg.offset))
                      : (w_avg - NUM_W'(i_cfg.offset));
    assign w_num_neg  = '0 - w_num;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5_mag       <= w_num[NUM_W-1] ? w_num_neg[MAG_W-1:0] : w_num[MAG_W-1:0];
            // A zero divisor divides as one
            r_s5_dvs       <= (i_cfg.divisor == '0) ? DIV_W'(1) : i_cfg.divisor;
            r_s5_side.zero <= r_s4_zero;
            r_s5_side.sok  <= r_s4_sok;
            r_s5_side.neg  <= w_num[NUM_W-1];
        end
    end

    // Divider stages
    logic [MAG_W-1:0] w_quo;
    t_side            w_div_side;

    tsfc_div u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r_s5_mag),
        .i_dvs  (r_s5_dvs),
        .i_side (r_s5_side),
        .o_quo  (w_quo),
        .o_side (w_div_side)
    );

    // Map: span minus signed quotient, clamped to 0..span
    logic [SPAN_W-1:0] r_scr;
    t_side             r_side;
    logic [SPAN_W-1:0] n_scr;

    always_comb begin
        if (w_div_side.neg) begin
            n_scr = i_cfg.span;
        end else if (w_quo >= MAG_W'(i_cfg.span)) begin
            n_scr = '0;
        end else begin
            n_scr = i_cfg.span - w_quo[SPAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scr  <= n_scr;
            r_side <= w_div_side;
        end
    end

    assign o_scr  = r_scr;
    assign o_side = r_side;

endmodule

`default_nettype wire

@@ design/touch_sample_filter_calibrate_core.sv @@
// Top level of the touch filter: config registers, X and Y lanes, status merge
// and output register. Depends on tsfc_pkg, tsfc_in_if, tsfc_out_if, tsfc_lane.
//
//   Channel   Dir  Handshake          Carries
//   i_in      in   valid/ready        pen_down, raw_x0..raw_x4, raw_y0..raw_y4
//   o_out     out  valid/ready        status, screen_x, screen_y, pressed
//   i_cfg_*   in   write enable only  register index and data, no read-back
//
// One transaction accepted per cycle while no result waits on o_out; each result passes
// through the lane stages, the one-bit-per-stage divider and the output register.
// The whole pipeline advances together and holds while a result waits on o_out.
// Reset clears the pipeline valid bits and loads the default calibration.
`default_nettype none

module touch_sample_filter_calibrate_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tsfc_in_if.sink                             i_in,
    tsfc_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [tsfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tsfc_pkg::CFG_W-1:0]     i_cfg_data
);
    import tsfc_pkg::*;

    // Configuration registers
    logic [OFF_W-1:0]  r_x_offset;
    logic [DIV_W-1:0]  r_x_divisor;
    logic [SPAN_W-1:0] r_x_span;
    logic [OFF_W-1:0]  r_y_offset;
    logic [DIV_W-1:0]  r_y_divisor;
    logic [SPAN_W-1:0] r_y_span;
    logic [FLIP_W-1:0] r_y_flip;
    logic [LIM_W-1:0]  r_spread_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset     <= RST_X_OFFSET;
            r_x_divisor    <= RST_X_DIVISOR;
            r_x_span       <= RST_X_SPAN;
            r_y_offset     <= RST_Y_OFFSET;
            r_y_divisor    <= RST_Y_DIVISOR;
            r_y_span       <= RST_Y_SPAN;
            r_y_flip       <= RST_Y_FLIP;
            r_spread_limit <= RST_SPREAD_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_OFFSET:     r_x_offset     <= i_cfg_data[OFF_W-1:0];
                CFG_X_DIVISOR:    r_x_divisor    <= i_cfg_data[DIV_W-1:0];
                CFG_X_SPAN:       r_x_span       <= i_cfg_data[SPAN_W-1:0];
                CFG_Y_OFFSET:     r_y_offset     <= i_cfg_data[OFF_W-1:0];
                CFG_Y_DIVISOR:    r_y_divisor    <= i_cfg_data[DIV_W-1:0];
                CFG_Y_SPAN:       r_y_span       <= i_cfg_data[SPAN_W-1:0];
                CFG_Y_FLIP:       r_y_flip       <= i_cfg_data[FLIP_W-1:0];
                CFG_SPREAD_LIMIT: r_spread_limit <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Lane settings
    t_lane_cfg w_cfg_x;
    t_lane_cfg w_cfg_y;

    assign w_cfg_x = '{offset: r_x_offset, divisor: r_x_divisor, span: r_x_span,
                       flip: '0, flip_en: 1'b0, limit: r_spread_limit};
    assign w_cfg_y = '{offset: r_y_offset, divisor: r_y_divisor, span: r_y_span,
                       flip: r_y_flip, flip_en: 1'b1, limit: r_spread_limit};

    // Pipeline advances unless a finished result is held on the output
    logic      r_out_vld;
    t_out_item r_out;
    logic      w_en;

    assign w_en       = !r_out_vld || o_out.ready;
    // Take no transaction while reset is held
    assign i_in.ready = w_en && i_rst_n;

    // Unpack the used samples of each axis
    t_raw      w_raw_x [RAW_COUNT];
    t_raw      w_raw_y [RAW_COUNT];
    t_samp_arr w_samp_x;
    t_samp_arr w_samp_y;

    assign w_raw_x = '{i_in.data.raw_x0, i_in.data.raw_x1, i_in.data.raw_x2,
                       i_in.data.raw_x3, i_in.data.raw_x4};
    assign w_raw_y = '{i_in.data.raw_y0, i_in.data.raw_y1, i_in.data.raw_y2,
                       i_in.data.raw_y3, i_in.data.raw_y4};

    always_comb begin
        for (int k = 0; k < SAMPLE_COUNT; k++) begin
            w_samp_x[k] = t_samp'(w_raw_x[k]);
            w_samp_y[k] = t_samp'(w_raw_y[k]);
        end
    end

    // Axis lanes
    logic [SPAN_W-1:0] w_scr_x;
    logic [SPAN_W-1:0] w_scr_y;
    t_side             w_side_x;
    t_side             w_side_y;

    tsfc_lane u_lane_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_samp (w_samp_x),
        .i_cfg  (w_cfg_x),
        .o_scr  (w_scr_x),
        .o_side (w_side_x)
    );

    tsfc_lane u_lane_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_samp (w_samp_y),
        .i_cfg  (w_cfg_y),
        .o_scr  (w_scr_y),
        .o_side (w_side_y)
    );

    // Valid and pen-down flags, delayed to match the lanes
    logic [LANE_LAT-1:0] r_vld;
    logic [LANE_LAT-1:0] r_pen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LANE_LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pen <= {r_pen[LANE_LAT-2:0], i_in.data.pen_down};
        end
    end

    // Merge lane findings into one status; zero test ranks above spread test
    t_out_item n_out;

    always_comb begin
        n_out.screen_x = SCR_IDLE;
        n_out.screen_y = SCR_IDLE;
        n_out.pressed  = 1'b0;
        if (!r_pen[LANE_LAT-1]) begin
            n_out.status = ST_PEN_UP;
        end else if (w_side_x.zero || w_side_y.zero) begin
            n_out.status = ST_ZERO;
        end else if (!w_side_x.sok || !w_side_y.sok) begin
            n_out.status = ST_SPREAD;
        end else begin
            n_out.status   = ST_OK;
            n_out.screen_x = w_scr_x;
            n_out.screen_y = w_scr_y;
            n_out.pressed  = 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

@@ bench/tsfc_result_checker.sv @@
// Result checker for the touch filter core: mirrors the calibration registers,
// predicts one result per accepted sample group and compares it on o_out.
// Depends on tsfc_pkg, tsfc_in_if and tsfc_out_if.

module tsfc_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tsfc_in_if                             i_in_mon,
    tsfc_out_if                            i_out_mon,
    input  logic                           i_cfg_we,
    input  logic [tsfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tsfc_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);
    import tsfc_pkg::*;

    typedef logic [SAMPLE_COUNT-1:0][ADC_BITS-1:0] t_axis;

    typedef struct packed {
        logic [OFF_W-1:0]  x_off;
        logic [DIV_W-1:0]  x_div;
        logic [SPAN_W-1:0] x_span;
        logic [OFF_W-1:0]  y_off;
        logic [DIV_W-1:0]  y_div;
        logic [SPAN_W-1:0] y_span;
        logic [FLIP_W-1:0] y_flip;
        logic [LIM_W-1:0]  limit;
    } t_calib;

    t_calib    cal;
    t_out_item coord_q[$];
    int        fail_cnt  = 0;
    int        result_no = 0;

    // Sort one axis, test the gaps of the middle three and return their mean.
    function automatic bit middle_mean(input t_axis smp, input logic [LIM_W-1:0] lim,
                                       output int avg);
        t_axis               s;
        logic [ADC_BITS-1:0] t;
        s = smp;
        for (int i = 0; i < SAMPLE_COUNT - 1; i++) begin
            for (int j = 0; j < SAMPLE_COUNT - 1 - i; j++) begin
                if (s[j] > s[j+1]) begin
                    t      = s[j];
                    s[j]   = s[j+1];
                    s[j+1] = t;
                end
            end
        end
        avg = (int'(s[MID-1]) + int'(s[MID]) + int'(s[MID+1])) / 3;
        return (int'(s[MID]) - int'(s[MID-1]) <= int'(lim)) &&
               (int'(s[MID+1]) - int'(s[MID]) <= int'(lim));
    endfunction

    // Scale a signed numerator to pixels: truncating divide, subtract, saturate.
    function automatic logic [SPAN_W-1:0] to_screen(input longint num,
                                                    input logic [DIV_W-1:0] dv,
                                                    input logic [SPAN_W-1:0] span);
        longint d;
        longint r;
        d = (dv == '0) ? 64'sd1 : longint'(dv);
        r = longint'(span) - num / d;
        if (r < 0) r = 0;
        if (r > longint'(span)) r = longint'(span);
        return r[SPAN_W-1:0];
    endfunction

    // Work out the result that one sample group produces under calibration c.
    function automatic t_out_item calibrate_group(input t_in_item grp, input t_calib c);
        t_out_item res;
        t_axis     xs;
        t_axis     ys;
        bit        has_zero;
        bit        ok_x;
        bit        ok_y;
        int        ax;
        int        ay;
        res.status   = ST_PEN_UP;
        res.screen_x = SCR_IDLE;
        res.screen_y = SCR_IDLE;
        res.pressed  = 1'b0;
        xs = {grp.raw_x4, grp.raw_x3, grp.raw_x2, grp.raw_x1, grp.raw_x0};
        ys = {grp.raw_y4, grp.raw_y3, grp.raw_y2, grp.raw_y1, grp.raw_y0};
        if (grp.pen_down) begin
            has_zero = 1'b0;
            for (int i = 0; i < SAMPLE_COUNT; i++) begin
                if (xs[i] == '0 || ys[i] == '0) has_zero = 1'b1;
            end
            if (has_zero) begin
                res.status = ST_ZERO;
            end else begin
                ok_x = middle_mean(xs, c.limit, ax);
                ok_y = middle_mean(ys, c.limit, ay);
                if (!(ok_x && ok_y)) begin
                    res.status = ST_SPREAD;
                end else begin
                    res.status   = ST_OK;
                    res.pressed  = 1'b1;
                    res.screen_x = to_screen(longint'(ax) - longint'(c.x_off),
                                             c.x_div, c.x_span);
                    res.screen_y = to_screen(longint'(c.y_flip) - longint'(ay) -
                                             longint'(c.y_off), c.y_div, c.y_span);
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            // Load the power-on calibration and forget anything in flight
            cal.x_off  = RST_X_OFFSET;
            cal.x_div  = RST_X_DIVISOR;
            cal.x_span = RST_X_SPAN;
            cal.y_off  = RST_Y_OFFSET;
            cal.y_div  = RST_Y_DIVISOR;
            cal.y_span = RST_Y_SPAN;
            cal.y_flip = RST_Y_FLIP;
            cal.limit  = RST_SPREAD_LIMIT;
            coord_q.delete();
        end else begin
            // Retire the result transaction taken at this edge
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.data;
                result_no++;
                if (coord_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("result %0d: unexpected, status %0d x %0d y %0d pressed %0d",
                                 result_no, got.status, got.screen_x, got.screen_y,
                                 got.pressed);
                end else begin
                    want = coord_q.pop_front();
                    if (got.status !== want.status || got.screen_x !== want.screen_x ||
                        got.screen_y !== want.screen_y || got.pressed !== want.pressed) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"result %0d mismatch (expected/actual): status %0d/%0d ",
                                      "x %0d/%0d y %0d/%0d pressed %0d/%0d"},
                                     result_no, want.status, got.status, want.screen_x,
                                     got.screen_x, want.screen_y, got.screen_y,
                                     want.pressed, got.pressed);
                    end
                end
            end
            // Predict each sample group transaction as it is taken
            if (i_in_mon.valid && i_in_mon.ready)
                coord_q.push_back(calibrate_group(i_in_mon.data, cal));
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_OFFSET:     cal.x_off  = i_cfg_data[OFF_W-1:0];
                    CFG_X_DIVISOR:    cal.x_div  = i_cfg_data[DIV_W-1:0];
                    CFG_X_SPAN:       cal.x_span = i_cfg_data[SPAN_W-1:0];
                    CFG_Y_OFFSET:     cal.y_off  = i_cfg_data[OFF_W-1:0];
                    CFG_Y_DIVISOR:    cal.y_div  = i_cfg_data[DIV_W-1:0];
                    CFG_Y_SPAN:       cal.y_span = i_cfg_data[SPAN_W-1:0];
                    CFG_Y_FLIP:       cal.y_flip = i_cfg_data[FLIP_W-1:0];
                    CFG_SPREAD_LIMIT: cal.limit  = i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= coord_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

@@ bench/tb_touch_sample_filter_calibrate_core.sv @@
// Testbench top for touch_sample_filter_calibrate_core: clock, reset, sample
// group stimulus, register settings, output back-pressure and the verdict.
// Depends on tsfc_pkg, tsfc_in_if, tsfc_out_if, the core and tsfc_result_checker.

module tb_touch_sample_filter_calibrate_core;
    import tsfc_pkg::*;

    typedef logic [SAMPLE_COUNT-1:0][ADC_BITS-1:0] t_axis;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 142;
    localparam int HOLD_CYCLES = 150;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   pending;
    int                   fail_count;
    int                   pressure_seq;
    int                   cycle_cnt = 0;
    int                   cal_val [8];
    int                   send_left = 0;
    bit                   send_steady;

    tsfc_in_if  in_bus ();
    tsfc_out_if out_bus ();

    touch_sample_filter_calibrate_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tsfc_result_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_touch_sample_filter_calibrate_core: FAIL");
            $finish;
        end
    end

    function automatic t_in_item pack_group(input logic pen, input t_axis xs, input t_axis ys);
        t_in_item g;
        g.pen_down = pen;
        g.raw_x0   = xs[0];
        g.raw_x1   = xs[1];
        g.raw_x2   = xs[2];
        g.raw_x3   = xs[3];
        g.raw_x4   = xs[4];
        g.raw_y0   = ys[0];
        g.raw_y1   = ys[1];
        g.raw_y2   = ys[2];
        g.raw_y3   = ys[3];
        g.raw_y4   = ys[4];
        return g;
    endfunction

    // Draw one axis: mostly a tight cluster, some groups straddling the spread
    // limit, some raw noise.
    function automatic t_axis axis_samples(input bit is_x);
        t_axis               s;
        logic [ADC_BITS-1:0] t;
        int                  lim;
        int                  pick;
        int                  center;
        int                  window;
        int                  v;
        int                  g1;
        int                  g2;
        int                  base;
        int                  j;
        lim  = cal_val[CFG_SPREAD_LIMIT];
        pick = $urandom_range(0, 99);
        if (pick < 15 && 2 * lim + 4 < 4000) begin
            // Middle gaps at or just past the limit, outer samples beyond them
            g1   = lim + int'($urandom_range(0, 2) == 0);
            g2   = lim + int'($urandom_range(0, 2) == 0);
            base = $urandom_range(1, 4094 - g1 - g2);
            s[0] = base[ADC_BITS-1:0];
            v    = base + g1;
            s[1] = v[ADC_BITS-1:0];
            v    = v + g2;
            s[2] = v[ADC_BITS-1:0];
            s[3] = ADC_BITS'($urandom_range(1, base));
            s[4] = ADC_BITS'($urandom_range(v, 4095));
            for (int i = SAMPLE_COUNT - 1; i > 0; i--) begin
                j    = $urandom_range(0, i);
                t    = s[i];
                s[i] = s[j];
                s[j] = t;
            end
        end else if (pick < 25) begin
            for (int i = 0; i < SAMPLE_COUNT; i++) s[i] = ADC_BITS'($urandom_range(0, 4095));
        end else begin
            // Center anywhere, or inside the window that maps onto the screen
            if (is_x) window = cal_val[CFG_X_SPAN] * (cal_val[CFG_X_DIVISOR] + 1);
            else window = cal_val[CFG_Y_SPAN] * (cal_val[CFG_Y_DIVISOR] + 1);
            v = $urandom_range(0, window);
            if ($urandom_range(0, 1)) center = $urandom_range(1, 4095);
            else if (is_x) center = cal_val[CFG_X_OFFSET] + v;
            else center = cal_val[CFG_Y_FLIP] - cal_val[CFG_Y_OFFSET] - v;
            for (int i = 0; i < SAMPLE_COUNT; i++) begin
                v = $urandom_range(0, lim);
                v = center - lim / 2 + v;
                if (v < 1) v = 1;
                if (v > 4095) v = 4095;
                s[i] = v[ADC_BITS-1:0];
                // Drop in a stray sample now and then
                if ($urandom_range(0, 11) == 0) s[i] = ADC_BITS'($urandom_range(1, 4095));
            end
        end
        return s;
    endfunction

    // Register value for a given calibration phase
    function automatic int setting_value(input int ph, input int idx);
        int v;
        case (ph)
            1: begin
                // minimum of every register but the spans, which are one; zero divisors included
                if (idx == CFG_X_SPAN || idx == CFG_Y_SPAN) v = 1;
                else v = 0;
            end
            2: begin
                if (idx == CFG_X_SPAN || idx == CFG_Y_SPAN) v = 1023;
                else if (idx == CFG_Y_FLIP) v = 8191;
                else v = 4095;
            end
            3: begin
                if (idx == CFG_X_DIVISOR || idx == CFG_Y_DIVISOR) v = 1;
                else if (idx == CFG_X_SPAN || idx == CFG_Y_SPAN) v = 1023;
                else if (idx == CFG_Y_FLIP) v = $urandom_range(0, 8191);
                else if (idx == CFG_SPREAD_LIMIT) v = $urandom_range(0, 40);
                else v = $urandom_range(0, 4095);
            end
            4: v = $urandom_range(0, 8191);
            default: begin
                if (idx == CFG_X_DIVISOR || idx == CFG_Y_DIVISOR) v = $urandom_range(1, 16);
                else if (idx == CFG_X_SPAN || idx == CFG_Y_SPAN) v = $urandom_range(100, 1023);
                else if (idx == CFG_Y_FLIP) v = $urandom_range(3900, 4400);
                else if (idx == CFG_SPREAD_LIMIT) v = $urandom_range(5, 100);
                else v = $urandom_range(0, 400);
            end
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_W-1:0];
        case (idx)
            CFG_X_SPAN, CFG_Y_SPAN: cal_val[idx] = value & ((1 << SPAN_W) - 1);
            CFG_Y_FLIP:             cal_val[idx] = value & ((1 << FLIP_W) - 1);
            default:                cal_val[idx] = value & ((1 << OFF_W) - 1);
        endcase
        @(posedge i_clk);
    endtask

    // Offer one group after a random gap and hold it until it is taken
    task automatic send_group(input t_in_item grp);
        int gap;
        if (send_left == 0) begin
            send_steady = ($urandom_range(0, 3) == 0);
            send_left   = $urandom_range(20, 150);
        end
        send_left--;
        gap = $urandom_range(0, 9);
        if (send_steady || gap < 6) gap = 0;
        else if (gap < 9) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data  <= grp;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic drain_results();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Output side: random stalls, calm stretches and a long hold on request
    initial begin : receiver
        int  stall_left;
        int  hold_left;
        int  seen_seq;
        int  mode_left;
        bit  steady;
        out_bus.ready <= 1'b0;
        stall_left = 0;
        hold_left  = 0;
        seen_seq   = 0;
        mode_left  = 0;
        steady     = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (pressure_seq != seen_seq) begin
                seen_seq  = pressure_seq;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(10, 40);
                else stall_left = $urandom_range(0, 2);
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        t_axis xs;
        t_axis ys;
        int    k;
        in_bus.valid <= 1'b0;
        in_bus.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_data     <= '0;
        pressure_seq <= 0;
        i_rst_n      <= 1'b0;
        cal_val[CFG_X_OFFSET]     = int'(RST_X_OFFSET);
        cal_val[CFG_X_DIVISOR]    = int'(RST_X_DIVISOR);
        cal_val[CFG_X_SPAN]       = int'(RST_X_SPAN);
        cal_val[CFG_Y_OFFSET]     = int'(RST_Y_OFFSET);
        cal_val[CFG_Y_DIVISOR]    = int'(RST_Y_DIVISOR);
        cal_val[CFG_Y_SPAN]       = int'(RST_Y_SPAN);
        cal_val[CFG_Y_FLIP]       = int'(RST_Y_FLIP);
        cal_val[CFG_SPREAD_LIMIT] = int'(RST_SPREAD_LIMIT);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed groups under the power-on calibration
        // pen up, samples ignored even when zero or widely spread
        send_group(pack_group(1'b0, {5{12'hA5C}}, {5{12'h3C5}}));
        send_group(pack_group(1'b0, '0, {12'd0, 12'd4095, 12'd7, 12'd2000, 12'd0}));
        // full scale and smallest nonzero, both saturating
        send_group(pack_group(1'b1, {5{12'hFFF}}, {5{12'hFFF}}));
        send_group(pack_group(1'b1, {5{12'd1}}, {5{12'd1}}));
        // zero sample on one axis only
        send_group(pack_group(1'b1, {12'd248, 12'd248, 12'd0, 12'd248, 12'd248},
                              {5{12'd3948}}));
        send_group(pack_group(1'b1, {5{12'd248}},
                              {12'd3948, 12'd3948, 12'd3948, 12'd3948, 12'd0}));
        // in-range mapping, and a negative numerator that truncates toward zero
        send_group(pack_group(1'b1, {5{12'd248}}, {5{12'd3948}}));
        send_group(pack_group(1'b1, {5{12'd222}}, {5{12'd3982}}));
        send_group(pack_group(1'b1, {5{12'd185}}, {5{12'd3950}}));
        // middle gaps exactly at the limit, then one count past it on each axis
        send_group(pack_group(1'b1, {12'd300, 12'd320, 12'd340, 12'd100, 12'd500},
                              {5{12'd3948}}));
        send_group(pack_group(1'b1, {12'd300, 12'd321, 12'd342, 12'd100, 12'd500},
                              {5{12'd3948}}));
        send_group(pack_group(1'b1, {5{12'd248}},
                              {12'd3900, 12'd3921, 12'd3941, 12'd3800, 12'd4000}));
        // far outliers at both ends are dropped by the sort
        send_group(pack_group(1'b1, {12'd1, 12'd4095, 12'd250, 12'd250, 12'd250},
                              {12'd3948, 12'd3950, 12'd1, 12'd4095, 12'd3949}));
        // zero test wins over a bad spread
        send_group(pack_group(1'b1, {12'd0, 12'd4095, 12'd1, 12'd2048, 12'd17},
                              {12'd5, 12'd4000, 12'd900, 12'd30, 12'd2500}));
        // alternating bit patterns, rejected on spread, then a mid-scale group that is accepted
        send_group(pack_group(1'b1, {12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA},
                              {12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555}));
        send_group(pack_group(1'b1, {5{12'h800}}, {5{12'h7FF}}));

        // Random groups, one calibration setting per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                for (int r = CFG_X_OFFSET; r <= CFG_SPREAD_LIMIT; r++)
                    write_reg(r[CFG_IDX_W-1:0], setting_value(ph, r));
                cfg_we <= 1'b0;
            end
            // Hold off the output for a long stretch while groups keep coming
            if (ph == 1 || ph == 5) pressure_seq <= pressure_seq + 1;
            repeat (PHASE_ITEMS) begin
                xs = axis_samples(1'b1);
                ys = axis_samples(1'b0);
                // knock out a sample now and then to reach the zero test
                if ($urandom_range(0, 19) == 0) begin
                    k = $urandom_range(0, SAMPLE_COUNT - 1);
                    if ($urandom_range(0, 1)) xs[k] = '0;
                    else ys[k] = '0;
                end
                send_group(pack_group($urandom_range(0, 9) != 0, xs, ys));
            end
        end

        drain_results();
        repeat (LANE_LAT + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_touch_sample_filter_calibrate_core: PASS");
        end else begin
            $display("tb_touch_sample_filter_calibrate_core: FAIL");
        end
        $finish;
    end

endmodule

@@ touch_sample_filter_calibrate_core.f @@
design/tsfc_pkg.sv
design/tsfc_in_if.sv
design/tsfc_out_if.sv
design/tsfc_div.sv
design/tsfc_lane.sv
design/touch_sample_filter_calibrate_core.sv
bench/tsfc_result_checker.sv
bench/tb_touch_sample_filter_calibrate_core.sv
